// ===== rtl/core/sha1bsh_pkg.sv =====
package sha1bsh_pkg;

    // Initial chaining values.
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_GROUP0 = 32'h5A827999;
    localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

    // Padding bytes and block geometry.
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_PAD_MARK,
        SEL_ZERO,
        SEL_LENGTH
    } byte_sel_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY1,
        PH_MAJORITY,
        PH_PARITY2
    } round_phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         byte_we;
        byte_sel_t    byte_sel;
        logic         count_inc;
        logic         round_step;
        round_phase_t round_phase;
        logic         fold;
        logic         reinit;
        logic [2:0]   out_idx;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
    } dp_status_t;

    // Round constant for a phase.
    function automatic logic [31:0] round_const(input round_phase_t ph);
        logic [31:0] k;
        unique case (ph)
            PH_CHOOSE:   k = K_GROUP0;
            PH_PARITY1:  k = K_GROUP1;
            PH_MAJORITY: k = K_GROUP2;
            default:     k = K_GROUP3;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/sha1bsh_dp.sv =====
module sha1bsh_dp
    import sha1bsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_byte,
    output dp_status_t  status,
    output logic [31:0] digest_word
);

    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  fill_reg;
    logic [63:0] count_reg;

    logic [7:0]  wr_byte;
    logic [63:0] bit_len;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] w_mix;
    logic [31:0] w_new;

    assign status.fill_last   = (fill_reg == FILL_LAST);
    assign status.fill_at_len = (fill_reg == LEN_OFFSET);

    // Bit length of the message, modulo 2^64.
    assign bit_len = {count_reg[60:0], 3'b000};

    // Byte source for the block buffer.
    always_comb begin
        case (cmd.byte_sel)
            SEL_INPUT:    wr_byte = data_byte;
            SEL_PAD_MARK: wr_byte = PAD_MARK;
            SEL_ZERO:     wr_byte = PAD_ZERO;
            default:      wr_byte = bit_len[8 * (7 - fill_reg[2:0]) +: 8];
        endcase
    end

    // Round function for the current group of rounds.
    always_comb begin
        case (cmd.round_phase)
            PH_CHOOSE:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            PH_MAJORITY: f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default:     f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg
                 + round_const(cmd.round_phase) + w_reg[0];

    // Next schedule word from the sliding sixteen-word window.
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Chaining words after adding the working variables.
    always_comb begin
        chain_next[0] = chain_reg[0] + a_reg;
        chain_next[1] = chain_reg[1] + b_reg;
        chain_next[2] = chain_reg[2] + c_reg;
        chain_next[3] = chain_reg[3] + d_reg;
        chain_next[4] = chain_reg[4] + e_reg;
    end

    // Chaining words, working variables, fill index and byte count.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
            a_reg        <= H0_INIT;
            b_reg        <= H1_INIT;
            c_reg        <= H2_INIT;
            d_reg        <= H3_INIT;
            e_reg        <= H4_INIT;
            fill_reg     <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.byte_we) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + 64'd1;
            end
            if (cmd.round_step) begin
                a_reg <= t_val;
                b_reg <= a_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                d_reg <= c_reg;
                e_reg <= d_reg;
            end else if (cmd.fold) begin
                for (int i = 0; i < 5; i++) begin
                    chain_reg[i] <= chain_next[i];
                end
                a_reg <= chain_next[0];
                b_reg <= chain_next[1];
                c_reg <= chain_next[2];
                d_reg <= chain_next[3];
                e_reg <= chain_next[4];
            end
        end
    end

    // Block buffer held as sixteen big-endian words; it shifts during rounds.
    always_ff @(posedge aclk) begin
        if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end else if (cmd.byte_we) begin
            case (fill_reg[1:0])
                2'd0:    w_reg[fill_reg[5:2]][31:24] <= wr_byte;
                2'd1:    w_reg[fill_reg[5:2]][23:16] <= wr_byte;
                2'd2:    w_reg[fill_reg[5:2]][15:8]  <= wr_byte;
                default: w_reg[fill_reg[5:2]][7:0]   <= wr_byte;
            endcase
        end
    end

    // Digest word selection.
    always_comb begin
        case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

// ===== rtl/core/sha1bsh_ctrl.sv =====
module sha1bsh_ctrl
    import sha1bsh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       byte_valid,
    input  logic       end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] word_number,
    output logic       final_word,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [6:0] round_cnt_reg, round_cnt_next;
    logic [2:0] out_cnt_reg, out_cnt_next;
    logic       finish_reg, finish_next;
    logic       first_reg, first_next;
    logic       len_reg, len_next;
    logic       done_reg, done_next;
    logic       is_len;

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            out_cnt_reg   <= '0;
            finish_reg    <= 1'b0;
            first_reg     <= 1'b0;
            len_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            finish_reg    <= finish_next;
            first_reg     <= first_next;
            len_reg       <= len_next;
            done_reg      <= done_next;
        end
    end

    assign word_number = out_cnt_reg;
    assign final_word  = (out_cnt_reg == WORD_LAST);

    // In the padding phase, the length field starts at offset 56 after the marker byte.
    assign is_len = !first_reg && (len_reg || status.fill_at_len);

    // Next state and datapath commands.
    always_comb begin
        state_next      = state_reg;
        round_cnt_next  = round_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        finish_next     = finish_reg;
        first_next      = first_reg;
        len_next        = len_reg;
        done_next       = done_reg;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        cmd.byte_we     = 1'b0;
        cmd.byte_sel    = SEL_INPUT;
        cmd.count_inc   = 1'b0;
        cmd.round_step  = 1'b0;
        cmd.round_phase = PH_CHOOSE;
        cmd.fold        = 1'b0;
        cmd.reinit      = 1'b0;
        cmd.out_idx     = out_cnt_reg;

        if (round_cnt_reg >= 7'd60) begin
            cmd.round_phase = PH_PARITY2;
        end else if (round_cnt_reg >= 7'd40) begin
            cmd.round_phase = PH_MAJORITY;
        end else if (round_cnt_reg >= 7'd20) begin
            cmd.round_phase = PH_PARITY1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.byte_we   = byte_valid;
                    cmd.count_inc = byte_valid;
                    finish_next   = end_of_message;
                    first_next    = end_of_message;
                    len_next      = 1'b0;
                    done_next     = 1'b0;
                    if (byte_valid && status.fill_last) begin
                        round_cnt_next = '0;
                        state_next     = ST_ROUND;
                    end else if (end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                round_cnt_next = round_cnt_reg + 7'd1;
                if (round_cnt_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (done_reg) begin
                    out_cnt_next = '0;
                    state_next   = ST_OUT;
                end else if (finish_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                cmd.byte_we = 1'b1;
                if (first_reg) begin
                    cmd.byte_sel = SEL_PAD_MARK;
                end else if (is_len) begin
                    cmd.byte_sel = SEL_LENGTH;
                end else begin
                    cmd.byte_sel = SEL_ZERO;
                end
                first_next = 1'b0;
                len_next   = is_len;
                if (status.fill_last) begin
                    done_next      = is_len;
                    round_cnt_next = '0;
                    state_next     = ST_ROUND;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (out_cnt_reg == WORD_LAST) begin
                        cmd.reinit   = 1'b1;
                        out_cnt_next = '0;
                        finish_next  = 1'b0;
                        first_next   = 1'b0;
                        len_next     = 1'b0;
                        done_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        out_cnt_next = out_cnt_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sha1_byte_stream_hasher.sv =====
// SHA-1 hasher fed one message byte per input word.
// Input channel (s_): a word carries s_data_byte, used when s_byte_valid is set,
// and s_end_of_message, which closes the message. A word with the end mark and
// no valid byte finishes the message with the bytes already fed.
// Output channel (m_): five digest words per message, h0 first, each with its
// index in m_word_number; m_final_word marks the fifth.
// Input: bytes are taken back to back until one completes a 64-byte block;
// that byte is followed by the 80 rounds of the single round unit and the
// addition into the chaining words, during which no input is taken.
// Finishing: padding is written one byte per cycle (9 to 72 bytes), with one
// or two block compressions; the first digest word is valid once the last
// compression has been added into the chaining words.
// The next message is taken once the fifth digest word has been accepted;
// while m_ready is low the current digest word holds and no input is taken.
// Reset loads the initial chaining words and clears the fill index and length.
module sha1_byte_stream_hasher
    import sha1bsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_number,
    output logic        m_final_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer for loading, rounds, padding and digest output.
    sha1bsh_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .byte_valid     (s_byte_valid),
        .end_of_message (s_end_of_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .word_number    (m_word_number),
        .final_word     (m_final_word),
        .status         (status),
        .cmd            (cmd)
    );

    // Block buffer, schedule, round unit and chaining words.
    sha1bsh_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_data_byte),
        .status      (status),
        .digest_word (m_digest_word)
    );

endmodule
